// File: rtl/arpt_pkg.sv
// shared constants, types and codes for the arp reply table tracker
package arpt_pkg;

    localparam int ENTRY_BITS_DEF = 8;
    localparam int MAC_SLOTS_DEF  = 3;
    localparam int SCAN_SLOTS_DEF = 128;

    localparam logic [15:0] ETHER_ARP = 16'h0806;
    localparam logic [15:0] OP_REPLY  = 16'h0002;
    localparam int PERCENT     = 100;
    localparam int WALK_LANES  = 8;
    localparam int NUM_W       = 15;

    // register index (byte address bits [3:2])
    localparam logic [1:0] REG_SUBNET = 2'd0;
    localparam logic [1:0] REG_HOST   = 2'd1;
    localparam logic [1:0] REG_SCANS  = 2'd2;

    localparam logic [31:0] SUBNET_RST = 32'd0;
    localparam logic [3:0]  HOST_RST   = 4'd8;
    localparam logic [7:0]  SCANS_RST  = 8'd10;

    // result status codes
    localparam logic [2:0] STAT_NOT_ARP   = 3'd0;
    localparam logic [2:0] STAT_NOT_REPLY = 3'd1;
    localparam logic [2:0] STAT_RANGE     = 3'd2;
    localparam logic [2:0] STAT_NEW       = 3'd3;
    localparam logic [2:0] STAT_KNOWN     = 3'd4;
    localparam logic [2:0] STAT_FULL      = 3'd5;
    localparam logic [2:0] STAT_READ_DONE = 3'd6;
    localparam logic [2:0] STAT_BAD_SCAN  = 3'd7;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_REC_RD,
        S_REC_CHK,
        S_RD_RD,
        S_RD_WAIT,
        S_RD_WALK,
        S_RD_NEXT,
        S_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic slot_rst;
        logic slot_inc;
        logic mem_rd;
        logic rec_wr;
        logic walk_rst;
        logic walk_step;
        logic acc_rst;
        logic mac_cap;
        logic dev_acc;
        logic div_start;
        logic res_pre;
        logic res_hit;
        logic res_full;
        logic res_read;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic pre_drop;
        logic is_read;
        logic row_hit;
        logic row_empty;
        logic slot_last;
        logic chunk_last;
        logic clr_last;
        logic div_done;
    } sts_t;

endpackage

// File: rtl/arpt_ram.sv
// generic single write, single read ram with registered read data
module arpt_ram #(
    parameter int W = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// File: rtl/arpt_div.sv
// restoring divider, one quotient bit per cycle
module arpt_div #(
    parameter int NW = 15,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int CNTW = $clog2(NW + 1);

    logic [DW:0]     rem_reg, rem_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   den_reg;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DW:0]     rem_sh;
    logic [DW+1:0]   diff;
    logic            ge;

    assign rem_sh = {rem_reg[DW-1:0], quo_reg[NW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};
    assign ge     = !diff[DW+1];

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = CNTW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DW:0] : rem_sh;
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: rtl/arpt_ctrl.sv
// sequencing state machine for record and readout
module arpt_ctrl import arpt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:   if (sts.clr_last) state_next = S_IDLE;
            S_IDLE:    if (in_valid) state_next = S_CHECK;
            S_CHECK:
            begin
                if (sts.pre_drop)
                    state_next = S_OUT;
                else if (sts.is_read)
                    state_next = S_RD_RD;
                else
                    state_next = S_REC_RD;
            end
            S_REC_RD:  state_next = S_REC_CHK;
            S_REC_CHK:
            begin
                if (sts.row_hit || sts.slot_last)
                    state_next = S_OUT;
                else
                    state_next = S_REC_RD;
            end
            S_RD_RD:   state_next = S_RD_WAIT;
            S_RD_WAIT: state_next = sts.row_empty ? S_DIV : S_RD_WALK;
            S_RD_WALK: if (sts.chunk_last) state_next = S_RD_NEXT;
            S_RD_NEXT: state_next = sts.slot_last ? S_DIV : S_RD_RD;
            S_DIV:     if (sts.div_done) state_next = S_OUT;
            S_OUT:     if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_CLEAR: cmd.clr_wr = 1'b1;
            S_IDLE:  cmd.load = in_valid;
            S_CHECK:
            begin
                if (sts.pre_drop)
                begin
                    cmd.res_pre = 1'b1;
                end
                else
                begin
                    cmd.slot_rst = 1'b1;
                    cmd.acc_rst  = 1'b1;
                end
            end
            S_REC_RD: cmd.mem_rd = 1'b1;
            S_REC_CHK:
            begin
                if (sts.row_hit)
                begin
                    cmd.rec_wr  = 1'b1;
                    cmd.res_hit = 1'b1;
                end
                else if (sts.slot_last)
                    cmd.res_full = 1'b1;
                else
                    cmd.slot_inc = 1'b1;
            end
            S_RD_RD:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.walk_rst = 1'b1;
            end
            S_RD_WAIT:
            begin
                if (sts.row_empty)
                    cmd.div_start = 1'b1;
                else
                    cmd.mac_cap = 1'b1;
            end
            S_RD_WALK: cmd.walk_step = 1'b1;
            S_RD_NEXT:
            begin
                cmd.dev_acc = 1'b1;
                if (sts.slot_last)
                    cmd.div_start = 1'b1;
                else
                    cmd.slot_inc = 1'b1;
            end
            S_DIV:   cmd.res_read = sts.div_done;
            S_OUT:   cmd.out_load = !out_valid_reg || out_ready;
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/arpt_dp.sv
// datapath: word capture, table ram, mark walk, divider and result registers
module arpt_dp import arpt_pkg::*; #(
    parameter int ENTRY_BITS = ENTRY_BITS_DEF,
    parameter int MAC_SLOTS  = MAC_SLOTS_DEF,
    parameter int SCAN_SLOTS = SCAN_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [31:0] subnet_base,
    input  logic [3:0]  host_bits,
    input  logic [7:0]  scans_in_use,
    input  logic        command,
    input  logic [15:0] ether_type,
    input  logic [15:0] arp_opcode,
    input  logic [31:0] src_ip,
    input  logic [47:0] src_mac,
    input  logic [6:0]  scan_index,
    input  logic [7:0]  entry_index,
    input  logic [1:0]  slot_index,
    output logic [2:0]  status,
    output logic [47:0] slot_mac,
    output logic        slot_used,
    output logic [7:0]  scans_replied,
    output logic [7:0]  scans_multi,
    output logic [6:0]  reply_percent,
    output logic [1:0]  devices_replied
);

    localparam int DEPTH = (1 << ENTRY_BITS) * MAC_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (MAC_SLOTS > 1) ? $clog2(MAC_SLOTS) : 1;
    localparam int MW    = 2 * SCAN_SLOTS;
    localparam int RW    = 48 + MW;
    localparam int NCH   = (SCAN_SLOTS + WALK_LANES - 1) / WALK_LANES;
    localparam int CW    = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int LW    = 2 * WALK_LANES;

    // captured word
    logic        cmd_reg;
    logic [15:0] ether_reg;
    logic [15:0] op_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic [6:0]  scan_reg;
    logic [7:0]  eidx_reg;
    logic [1:0]  sidx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= command;
            ether_reg <= ether_type;
            op_reg    <= arp_opcode;
            ip_reg    <= src_ip;
            mac_reg   <= src_mac;
            scan_reg  <= scan_index;
            eidx_reg  <= entry_index;
            sidx_reg  <= slot_index;
        end
    end

    // effective configuration
    logic [4:0]  hbe;
    logic [7:0]  scans_eff;
    logic [31:0] ent_full;
    logic        oob;
    logic        pre_drop;
    logic [2:0]  pre_code;

    assign hbe = ({1'b0, host_bits} > 5'(ENTRY_BITS)) ? 5'(ENTRY_BITS) : {1'b0, host_bits};

    always_comb
    begin
        scans_eff = scans_in_use;
        if (scans_in_use == 8'd0)
            scans_eff = 8'd1;
        else if (scans_in_use > 8'(SCAN_SLOTS))
            scans_eff = 8'(SCAN_SLOTS);
    end

    assign ent_full = cmd_reg ? 32'(eidx_reg) : (ip_reg - subnet_base);
    assign oob      = (ent_full >> hbe) != 32'd0;

    always_comb
    begin
        pre_drop = 1'b1;
        pre_code = STAT_RANGE;
        if (cmd_reg)
        begin
            pre_drop = oob || (32'(sidx_reg) >= 32'(MAC_SLOTS));
        end
        else if (ether_reg != ETHER_ARP)
            pre_code = STAT_NOT_ARP;
        else if (op_reg != OP_REPLY)
            pre_code = STAT_NOT_REPLY;
        else if (oob)
            pre_code = STAT_RANGE;
        else if ({1'b0, scan_reg} >= scans_eff)
            pre_code = STAT_BAD_SCAN;
        else if (mac_reg == 48'd0)
            pre_code = STAT_FULL;
        else
            pre_drop = 1'b0;
    end

    // entry and slot counter
    logic [ENTRY_BITS-1:0] ent_reg;
    logic [SW-1:0]         slot_reg, slot_next;
    logic [AW-1:0]         addr;
    logic                  is_tgt;

    always_comb
    begin
        slot_next = slot_reg;
        if (cmd.slot_rst)
            slot_next = '0;
        else if (cmd.slot_inc)
            slot_next = slot_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.slot_rst)
        begin
            ent_reg <= ent_full[ENTRY_BITS-1:0];
        end
    end

    assign addr   = AW'(ent_reg) * AW'(MAC_SLOTS) + AW'(slot_reg);
    assign is_tgt = (slot_reg == SW'(sidx_reg));

    // table ram, one row per entry and slot: mac over scan marks
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [RW-1:0] rdata;
    logic [47:0]   rd_mac;
    logic [MW-1:0] rd_marks, marks_upd;
    logic [1:0]    mark_old;

    assign clr_cnt_next = cmd.clr_wr ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
    assign rd_mac   = rdata[RW-1:MW];
    assign rd_marks = rdata[MW-1:0];

    always_comb
    begin
        marks_upd = rd_marks;
        mark_old  = rd_marks[2*scan_reg +: 2];
        if (mark_old < 2'd2)
            marks_upd[2*scan_reg +: 2] = mark_old + 2'd1;
    end

    arpt_ram #(
        .W     (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.clr_wr | cmd.rec_wr),
        .waddr (cmd.clr_wr ? clr_cnt_reg : addr),
        .wdata (cmd.clr_wr ? {RW{1'b0}} : {mac_reg, marks_upd}),
        .re    (cmd.mem_rd),
        .raddr (addr),
        .rdata (rdata)
    );

    // mark walk, WALK_LANES marks a cycle
    logic [CW-1:0]    chunk_reg, chunk_next;
    logic [NCH*LW-1:0] marks_pad;
    logic [LW-1:0]    lanes;
    logic [8:0]       k;
    logic [1:0]       m;
    logic [3:0]       cnt_r, cnt_m;
    logic             hit;

    assign marks_pad = (NCH*LW)'(rd_marks);
    assign lanes     = marks_pad[chunk_reg*LW +: LW];

    always_comb
    begin
        cnt_r = '0;
        cnt_m = '0;
        hit   = 1'b0;
        k     = '0;
        m     = '0;
        for (int l = 0; l < WALK_LANES; l++)
        begin
            k = 9'(chunk_reg) * 9'(WALK_LANES) + 9'(l);
            m = lanes[2*l +: 2];
            if (k < {1'b0, scans_eff})
            begin
                if (m != 2'd0)
                begin
                    cnt_r = cnt_r + 4'd1;
                    hit   = 1'b1;
                end
                if (m[1])
                    cnt_m = cnt_m + 4'd1;
            end
        end
    end

    always_comb
    begin
        chunk_next = chunk_reg;
        if (cmd.walk_rst)
            chunk_next = '0;
        else if (cmd.walk_step)
            chunk_next = chunk_reg + 1'b1;
    end

    // readout accumulators
    logic [7:0]  replied_reg, replied_next;
    logic [7:0]  multi_reg, multi_next;
    logic [1:0]  dev_reg, dev_next;
    logic [47:0] smac_reg, smac_next;
    logic        any_reg, any_next;

    always_comb
    begin
        replied_next = replied_reg;
        multi_next   = multi_reg;
        dev_next     = dev_reg;
        smac_next    = smac_reg;
        any_next     = any_reg;
        if (cmd.acc_rst)
        begin
            replied_next = '0;
            multi_next   = '0;
            dev_next     = '0;
            smac_next    = '0;
        end
        if (cmd.walk_rst)
            any_next = 1'b0;
        if (cmd.walk_step)
        begin
            any_next = any_reg | hit;
            if (is_tgt)
            begin
                replied_next = replied_reg + 8'(cnt_r);
                multi_next   = multi_reg + 8'(cnt_m);
            end
        end
        if (cmd.mac_cap && is_tgt)
            smac_next = rd_mac;
        if (cmd.dev_acc && any_reg && (dev_reg != 2'd3))
            dev_next = dev_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            slot_reg    <= '0;
            chunk_reg   <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            slot_reg    <= slot_next;
            chunk_reg   <= chunk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        replied_reg <= replied_next;
        multi_reg   <= multi_next;
        dev_reg     <= dev_next;
        smac_reg    <= smac_next;
        any_reg     <= any_next;
    end

    // percentage divide
    logic             div_done;
    logic [NUM_W-1:0] quo;

    arpt_div #(
        .NW (NUM_W),
        .DW (8)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (NUM_W'(replied_reg) * NUM_W'(PERCENT)),
        .den   (scans_eff),
        .done  (div_done),
        .quo   (quo)
    );

    // result and output registers
    logic [2:0]  res_status_reg;
    logic [47:0] res_mac_reg;
    logic [7:0]  res_replied_reg;
    logic [7:0]  res_multi_reg;
    logic [6:0]  res_pct_reg;
    logic [1:0]  res_dev_reg;
    logic        row_match;

    assign row_match = (rd_mac == mac_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.res_pre || cmd.res_hit || cmd.res_full)
        begin
            res_mac_reg     <= '0;
            res_replied_reg <= '0;
            res_multi_reg   <= '0;
            res_pct_reg     <= '0;
            res_dev_reg     <= '0;
        end
        if (cmd.res_pre)
            res_status_reg <= pre_code;
        if (cmd.res_hit)
            res_status_reg <= row_match ? STAT_KNOWN : STAT_NEW;
        if (cmd.res_full)
            res_status_reg <= STAT_FULL;
        if (cmd.res_read)
        begin
            res_status_reg  <= STAT_READ_DONE;
            res_mac_reg     <= smac_reg;
            res_replied_reg <= replied_reg;
            res_multi_reg   <= multi_reg;
            res_pct_reg     <= quo[6:0];
            res_dev_reg     <= dev_reg;
        end
        if (cmd.out_load)
        begin
            status          <= res_status_reg;
            slot_mac        <= res_mac_reg;
            slot_used       <= (res_mac_reg != 48'd0);
            scans_replied   <= res_replied_reg;
            scans_multi     <= res_multi_reg;
            reply_percent   <= res_pct_reg;
            devices_replied <= res_dev_reg;
        end
    end

    assign sts.pre_drop   = pre_drop;
    assign sts.is_read    = cmd_reg;
    assign sts.row_hit    = row_match || (rd_mac == 48'd0);
    assign sts.row_empty  = (rd_mac == 48'd0);
    assign sts.slot_last  = (slot_reg == SW'(MAC_SLOTS - 1));
    assign sts.chunk_last = (chunk_reg == CW'(NCH - 1));
    assign sts.clr_last   = (clr_cnt_reg == AW'(DEPTH - 1));
    assign sts.div_done   = div_done;

endmodule

// File: rtl/arp_reply_table_tracker_top.sv
// arp reply table tracker: register port, controller and datapath
// flow: a word dropped on header, range or scan checks goes straight to the output; a record
//   tries the slots in order, one table ram read each; a readout reads and walks the marks
//   of each slot up to the first empty one, then runs the divider
// throughput: one word in flight; the next is taken while a result waits at the output
// reset: the table ram is swept to zero, one row a cycle, all (2^ENTRY_BITS)*MAC_SLOTS
//   rows (768 by default), before the first word is taken
module arp_reply_table_tracker_top import arpt_pkg::*; #(
    parameter int ENTRY_BITS = ENTRY_BITS_DEF,
    parameter int MAC_SLOTS  = MAC_SLOTS_DEF,
    parameter int SCAN_SLOTS = SCAN_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [15:0] ether_type,
    input  logic [15:0] arp_opcode,
    input  logic [31:0] src_ip,
    input  logic [47:0] src_mac,
    input  logic [6:0]  scan_index,
    input  logic [7:0]  entry_index,
    input  logic [1:0]  slot_index,
    // result words
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [47:0] slot_mac,
    output logic        slot_used,
    output logic [7:0]  scans_replied,
    output logic [7:0]  scans_multi,
    output logic [6:0]  reply_percent,
    output logic [1:0]  devices_replied
);

    // configuration registers; the user must write them only while idle, the block does not enforce it
    logic [31:0] subnet_reg, subnet_next;
    logic [3:0]  host_reg, host_next;
    logic [7:0]  scans_reg, scans_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        subnet_next = subnet_reg;
        host_next   = host_reg;
        scans_next  = scans_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                REG_SUBNET: subnet_next = pwdata;
                REG_HOST:   host_next   = pwdata[3:0];
                REG_SCANS:  scans_next  = pwdata[7:0];
                default:    subnet_next = subnet_reg;  // write beyond the list is dropped
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SUBNET: prdata = subnet_reg;
            REG_HOST:   prdata = 32'(host_reg);
            REG_SCANS:  prdata = 32'(scans_reg);
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subnet_reg <= SUBNET_RST;
            host_reg   <= HOST_RST;
            scans_reg  <= SCANS_RST;
        end
        else
        begin
            subnet_reg <= subnet_next;
            host_reg   <= host_next;
            scans_reg  <= scans_next;
        end
    end

    // controller drives the datapath by commands and watches its status
    cmd_t cmd;
    sts_t sts;

    arpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    arpt_dp #(
        .ENTRY_BITS (ENTRY_BITS),
        .MAC_SLOTS  (MAC_SLOTS),
        .SCAN_SLOTS (SCAN_SLOTS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .subnet_base     (subnet_reg),
        .host_bits       (host_reg),
        .scans_in_use    (scans_reg),
        .command         (command),
        .ether_type      (ether_type),
        .arp_opcode      (arp_opcode),
        .src_ip          (src_ip),
        .src_mac         (src_mac),
        .scan_index      (scan_index),
        .entry_index     (entry_index),
        .slot_index      (slot_index),
        .status          (status),
        .slot_mac        (slot_mac),
        .slot_used       (slot_used),
        .scans_replied   (scans_replied),
        .scans_multi     (scans_multi),
        .reply_percent   (reply_percent),
        .devices_replied (devices_replied)
    );

endmodule

// File: test/tb_arp_reply_table_tracker_top.sv
// testbench for the arp reply table tracker: directed table, random words, predictor check
`timescale 1ns / 1ps

module tb_arp_reply_table_tracker_top;
    import arpt_pkg::*;

    localparam int N_ENTRIES   = 1 << ENTRY_BITS_DEF;
    localparam int N_MACS      = N_ENTRIES * MAC_SLOTS_DEF;
    localparam int N_MARKS     = N_MACS * SCAN_SLOTS_DEF;
    localparam int IDLE_LIMIT  = 4000;   // clear sweep, long hold-off and readouts fit well inside
    localparam int SETTLE_CYC  = 150;    // outlasts a readout
    localparam int HOLD_CYC    = 400;
    localparam logic [3:0] ADDR_JUNK = 4'd12;   // register index past the list

    // one input word and one result word
    typedef struct {
        bit        cmd;
        bit [15:0] eth;
        bit [15:0] op;
        bit [31:0] ip;
        bit [47:0] mac;
        bit [6:0]  scan;
        bit [7:0]  ent;
        bit [1:0]  slot;
    } arp_word_t;

    typedef struct {
        bit [2:0]  st;
        bit [47:0] mac;
        bit        used;
        bit [7:0]  replied;
        bit [7:0]  multi;
        bit [6:0]  pct;
        bit [1:0]  devs;
    } slot_report_t;

    // a directed row: the word and, where obvious, its status
    typedef struct {
        arp_word_t w;
        bit        typed;
        bit [2:0]  st;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid, in_ready;
    logic        command;
    logic [15:0] ether_type, arp_opcode;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
    logic [6:0]  scan_index;
    logic [7:0]  entry_index;
    logic [1:0]  slot_index;
    logic        out_valid, out_ready;
    logic [2:0]  status;
    logic [47:0] slot_mac;
    logic        slot_used;
    logic [7:0]  scans_replied, scans_multi;
    logic [6:0]  reply_percent;
    logic [1:0]  devices_replied;

    arp_reply_table_tracker_top u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .ether_type(ether_type), .arp_opcode(arp_opcode),
        .src_ip(src_ip), .src_mac(src_mac), .scan_index(scan_index),
        .entry_index(entry_index), .slot_index(slot_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .slot_mac(slot_mac), .slot_used(slot_used),
        .scans_replied(scans_replied), .scans_multi(scans_multi),
        .reply_percent(reply_percent), .devices_replied(devices_replied)
    );

    // shadow copy of the table and the registers
    bit [47:0] host_macs [N_MACS];
    bit [1:0]  scan_marks [N_MARKS];
    bit [31:0] cur_base;
    bit [3:0]  cur_host_bits;
    bit [7:0]  cur_scans;

    slot_report_t pending_reports [$];
    int          errors;
    int          words_sent;
    int          status_seen [8];
    bit          quiet;        // no idling on either side
    bit          hold_req;     // ask the receiver for a long hold-off
    int          hold_left;
    int          idle_cycles;
    bit [47:0]   mac_pool [6];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int live_entries();
        int hb;
        hb = (cur_host_bits > ENTRY_BITS_DEF) ? ENTRY_BITS_DEF : int'(cur_host_bits);
        return 1 << hb;
    endfunction

    function automatic int live_scans();
        int s;
        s = int'(cur_scans);
        if (s == 0) s = 1;
        if (s > SCAN_SLOTS_DEF) s = SCAN_SLOTS_DEF;
        return s;
    endfunction

    function automatic int mark_idx(int e, int sl, int sc);
        return (e * MAC_SLOTS_DEF + sl) * SCAN_SLOTS_DEF + sc;
    endfunction

    // work out the report for one word and update the shadow table
    function automatic slot_report_t track_word(arp_word_t w);
        slot_report_t r;
        bit [31:0]    off;
        int           e, sl, ns, dv;
        bit           any, done;
        r = '{default: 0};
        ns = live_scans();
        if (!w.cmd) begin
            off = w.ip - cur_base;
            if (w.eth != ETHER_ARP) r.st = STAT_NOT_ARP;
            else if (w.op != OP_REPLY) r.st = STAT_NOT_REPLY;
            else if (off >= live_entries()) r.st = STAT_RANGE;
            else if (w.scan >= ns) r.st = STAT_BAD_SCAN;
            else if (w.mac == 48'd0) r.st = STAT_FULL;
            else begin
                e = int'(off);
                r.st = STAT_FULL;
                done = 1'b0;
                for (sl = 0; sl < MAC_SLOTS_DEF; sl++) begin
                    if (!done && (host_macs[e*MAC_SLOTS_DEF+sl] == w.mac ||
                                  host_macs[e*MAC_SLOTS_DEF+sl] == 48'd0)) begin
                        r.st = (host_macs[e*MAC_SLOTS_DEF+sl] == w.mac) ? STAT_KNOWN : STAT_NEW;
                        host_macs[e*MAC_SLOTS_DEF+sl] = w.mac;
                        if (scan_marks[mark_idx(e, sl, w.scan)] < 2)
                            scan_marks[mark_idx(e, sl, w.scan)]++;
                        done = 1'b1;
                    end
                end
            end
        end else if (w.ent >= live_entries() || w.slot >= MAC_SLOTS_DEF) begin
            r.st = STAT_RANGE;
        end else begin
            e = int'(w.ent);
            r.st = STAT_READ_DONE;
            for (int k = 0; k < ns; k++) begin
                if (scan_marks[mark_idx(e, w.slot, k)] > 0) r.replied++;
                if (scan_marks[mark_idx(e, w.slot, k)] > 1) r.multi++;
            end
            // count slots in order up to the first empty one
            dv = 0;
            done = 1'b0;
            for (sl = 0; sl < MAC_SLOTS_DEF; sl++) begin
                if (host_macs[e*MAC_SLOTS_DEF+sl] == 48'd0) done = 1'b1;
                if (!done) begin
                    any = 1'b0;
                    for (int k = 0; k < ns; k++)
                        if (scan_marks[mark_idx(e, sl, k)] > 0) any = 1'b1;
                    if (any && dv < 3) dv++;
                end
            end
            r.devs = 2'(dv);
            r.mac = host_macs[e*MAC_SLOTS_DEF+w.slot];
            r.used = (r.mac != 48'd0);
            r.pct = 7'(int'(r.replied) * PERCENT / ns);
        end
        return r;
    endfunction

    // register write: setup then access cycle
    task automatic reg_write(logic [3:0] addr, logic [31:0] data);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (addr[3:2])
            REG_SUBNET: if (addr < ADDR_JUNK) cur_base = data;
            REG_HOST:   cur_host_bits = data[3:0];
            REG_SCANS:  cur_scans = data[7:0];
            default: ;
        endcase
    endtask

    // sender stops until every report is back
    task automatic drain_reports();
        while (pending_reports.size() != 0) @(posedge clk);
    endtask

    // offer one word, hold it until taken, then log the prediction
    task automatic send_word(arp_word_t w, bit typed, bit [2:0] typed_st);
        slot_report_t r;
        if (!quiet && $urandom_range(0, 99) < 13) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        command = w.cmd; ether_type = w.eth; arp_opcode = w.op; src_ip = w.ip;
        src_mac = w.mac; scan_index = w.scan; entry_index = w.ent; slot_index = w.slot;
        do @(posedge clk); while (!in_ready);
        r = track_word(w);
        // typed rows carry their status by hand, all other fields zero
        if (typed) r = '{st: typed_st, default: 0};
        pending_reports.push_back(r);
        words_sent++;
    endtask

    // mostly well-formed replies and reads into a few busy entries, some noise
    function automatic arp_word_t rand_word();
        arp_word_t w;
        int        pick, ne;
        w.cmd = 1'b0; w.eth = ETHER_ARP; w.op = OP_REPLY;
        w.mac = mac_pool[$urandom_range(0, 5)];
        w.scan = 7'($urandom_range(0, live_scans() - 1));
        w.ent = 8'($urandom); w.slot = 2'($urandom_range(0, 2));
        ne = live_entries();
        w.ip = cur_base + (($urandom_range(0, 3) == 0) ? $urandom_range(0, ne - 1)
                                                        : $urandom_range(0, (ne > 4) ? 3 : ne - 1));
        pick = $urandom_range(0, 99);
        if (pick < 5) w.scan = 7'($urandom);
        else if (pick < 9) w.ip = $urandom;
        else if (pick < 11) w.mac = 48'd0;
        else if (pick < 15) w.mac = 48'({$urandom, $urandom});
        else if (pick < 22) begin
            w.eth = 16'($urandom); w.op = 16'($urandom);
            if ($urandom_range(0, 1)) w.eth = ETHER_ARP;
        end else if (pick < 45) begin
            w.cmd = 1'b1;
            w.ent = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(w.ip - cur_base);
            w.slot = 2'($urandom);
            w.eth = 16'($urandom); w.op = 16'($urandom); w.ip = $urandom;
            w.mac = 48'({$urandom, $urandom});
        end
        return w;
    endfunction

    function automatic table_row_t row(bit cmd, bit [15:0] eth, bit [15:0] op, bit [31:0] ip,
                                       bit [47:0] mac, bit [6:0] scan, bit [7:0] ent,
                                       bit [1:0] slot, bit typed, bit [2:0] st);
        table_row_t t;
        t.w = '{cmd, eth, op, ip, mac, scan, ent, slot};
        t.typed = typed;
        t.st = st;
        return t;
    endfunction

    // result side: check every taken word against the oldest prediction
    always @(posedge clk) begin
        slot_report_t x;
        if (rst_n && out_valid && out_ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: result word with none expected, status %0d", $time, status);
                errors++;
            end else begin
                x = pending_reports.pop_front();
                status_seen[status]++;
                if (status != x.st) begin
                    $display("%0t: status exp %0d got %0d", $time, x.st, status); errors++;
                end
                if (slot_mac != x.mac) begin
                    $display("%0t: slot_mac exp %h got %h", $time, x.mac, slot_mac); errors++;
                end
                if (slot_used != x.used) begin
                    $display("%0t: slot_used exp %0d got %0d", $time, x.used, slot_used);
                    errors++;
                end
                if (scans_replied != x.replied) begin
                    $display("%0t: scans_replied exp %0d got %0d", $time, x.replied,
                             scans_replied);
                    errors++;
                end
                if (scans_multi != x.multi) begin
                    $display("%0t: scans_multi exp %0d got %0d", $time, x.multi, scans_multi);
                    errors++;
                end
                if (reply_percent != x.pct) begin
                    $display("%0t: reply_percent exp %0d got %0d", $time, x.pct, reply_percent);
                    errors++;
                end
                if (devices_replied != x.devs) begin
                    $display("%0t: devices_replied exp %0d got %0d", $time, x.devs,
                             devices_replied);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls, a quiet stretch and one long hold-off
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ready = 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYC;
            out_ready = 1'b0;
        end else begin
            out_ready = quiet ? 1'b1 : ($urandom_range(0, 99) >= 13);
        end
    end

    // watchdog: cycles in which no word moves on either channel
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog ran out, %0d results outstanding", $time,
                     pending_reports.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        table_row_t   dir_rows [$];
        arp_word_t    w;
        // settings per phase: base, host bits, scans; phases 3 and 4 hit the clamps
        bit [31:0]    ph_base [6];
        bit [3:0]     ph_host [6];
        bit [7:0]     ph_scans [6];
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; command = 1'b0; ether_type = '0; arp_opcode = '0;
        src_ip = '0; src_mac = '0; scan_index = '0; entry_index = '0; slot_index = '0;
        out_ready = 1'b1;
        errors = 0; words_sent = 0; quiet = 1'b0; hold_req = 1'b0; hold_left = 0;
        idle_cycles = 0;
        cur_base = SUBNET_RST; cur_host_bits = HOST_RST; cur_scans = SCANS_RST;
        foreach (host_macs[i]) host_macs[i] = '0;
        foreach (scan_marks[i]) scan_marks[i] = '0;
        foreach (status_seen[i]) status_seen[i] = 0;
        foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom}) | 48'd1;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at reset settings: base 0, 256 entries, 10 scans
        dir_rows.push_back(row(0, 16'hFFFF, OP_REPLY, 0, 1, 0, 0, 0, 1, STAT_NOT_ARP));
        dir_rows.push_back(row(0, 16'h0000, OP_REPLY, 0, 1, 0, 0, 0, 1, STAT_NOT_ARP));
        dir_rows.push_back(row(0, ETHER_ARP, 16'hFFFF, 0, 1, 0, 0, 0, 1, STAT_NOT_REPLY));
        dir_rows.push_back(row(0, ETHER_ARP, 16'h0000, 0, 1, 0, 0, 0, 1, STAT_NOT_REPLY));
        dir_rows.push_back(row(0, ETHER_ARP, OP_REPLY, 32'hFFFFFFFF, 1, 0, 0, 0, 1, STAT_RANGE));
        dir_rows.push_back(row(0, ETHER_ARP, OP_REPLY, 256, 1, 0, 0, 0, 1, STAT_RANGE));
        // scan index past the scan count
        dir_rows.push_back(row(0, ETHER_ARP, OP_REPLY, 0, 1, 127, 0, 0, 1, STAT_BAD_SCAN));
        dir_rows.push_back(row(0, ETHER_ARP, OP_REPLY, 0, 1, 10, 0, 0, 1, STAT_BAD_SCAN));
        // zero source mac cannot be stored
        dir_rows.push_back(row(0, ETHER_ARP, OP_REPLY, 0, 0, 0, 0, 0, 1, STAT_FULL));
        dir_rows.push_back(row(0, ETHER_ARP, OP_REPLY, 0, '1, 0, 0, 0, 1, STAT_NEW));
        dir_rows.push_back(row(0, ETHER_ARP, OP_REPLY, 0, '1, 0, 0, 0, 1, STAT_KNOWN));
        dir_rows.push_back(row(0, ETHER_ARP, OP_REPLY, 0, '1, 0, 0, 0, 1, STAT_KNOWN));
        dir_rows.push_back(row(0, ETHER_ARP, OP_REPLY, 0, 1, 9, 0, 0, 1, STAT_NEW));
        dir_rows.push_back(row(0, ETHER_ARP, OP_REPLY, 0, 2, 1, 0, 0, 1, STAT_NEW));
        // every slot taken by another mac
        dir_rows.push_back(row(0, ETHER_ARP, OP_REPLY, 0, 3, 1, 0, 0, 1, STAT_FULL));
        dir_rows.push_back(row(0, ETHER_ARP, OP_REPLY, 255, 48'h800000000000, 9, 0, 0,
                               1, STAT_NEW));
        dir_rows.push_back(row(1, 0, 0, 0, 0, 0, 0, 3, 1, STAT_RANGE));
        dir_rows.push_back(row(1, '1, '1, '1, '1, '1, 255, 0, 0, 0));
        dir_rows.push_back(row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(1, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        dir_rows.push_back(row(1, 0, 0, 0, 0, 0, 0, 2, 0, 0));
        dir_rows.push_back(row(1, 0, 0, 0, 0, 0, 5, 1, 0, 0));
        foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].st);

        ph_base  = '{32'h0A000000, 32'hC0A80100, 32'h00000000, 32'hFFFFFFF0,
                     32'h7F000000, 32'hFFFFFFFF};
        ph_host  = '{4'd8, 4'd2, 4'd0, 4'd15, 4'd3, 4'd8};
        ph_scans = '{8'd10, 8'd5, 8'd1, 8'd200, 8'd0, 8'd128};

        for (int p = 0; p < 6; p++) begin
            // config only while idle: all reports home, last readout settled
            @(negedge clk);
            in_valid = 1'b0;
            drain_reports();
            repeat (SETTLE_CYC) @(posedge clk);
            reg_write({REG_SUBNET, 2'b00}, ph_base[p]);
            reg_write({REG_HOST, 2'b00}, {$urandom} & 32'hFFFFFFF0 | 32'(ph_host[p]));
            reg_write({REG_SCANS, 2'b00}, 32'(ph_scans[p]));
            if (p == 2) reg_write(ADDR_JUNK, 32'hFFFFFFFF);
            for (int n = 0; n < 255; n++) begin
                quiet = (p == 1 && n >= 60 && n < 220);
                if (p == 2 && n == 20) hold_req = 1'b1;
                if (p == 3 && n == 100) begin
                    @(negedge clk);
                    in_valid = 1'b0;
                    drain_reports();
                end
                w = rand_word();
                send_word(w, 1'b0, 3'd0);
            end
            quiet = 1'b0;
        end

        @(negedge clk);
        in_valid = 1'b0;
        drain_reports();
        repeat (SETTLE_CYC) @(posedge clk);
        $display("ran %0d words over 7 register settings incl clamped host bits and scan counts",
                 words_sent);
        $display("status counts by code 0 to 7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/arpt_pkg.sv
rtl/arpt_ram.sv
rtl/arpt_div.sv
rtl/arpt_ctrl.sv
rtl/arpt_dp.sv
rtl/arp_reply_table_tracker_top.sv
test/tb_arp_reply_table_tracker_top.sv
